### hw/rtl/lsi_pkg.sv
// Shared types, widths and helpers for the segment crossing pipeline.
// Used by every module of line_segment_intersect; depends on nothing.
package lsi_pkg;

  // Coordinate width; every internal width below follows from it.
  localparam int CoordBits = 16;
  localparam int DiffBits  = CoordBits + 1;       // differences of two coordinates
  localparam int ProdBits  = 2 * DiffBits;        // product of two differences
  localparam int CrossBits = ProdBits + 1;        // difference of two products
  localparam int MagBits   = CrossBits - 1;       // magnitude of a cross product
  localparam int HalfBits  = MagBits / 2;         // split of a magnitude for multiplying
  localparam int PartBits  = HalfBits + CoordBits;
  localparam int DivBits   = MagBits + CoordBits; // dividend of the final division

  typedef logic signed [CoordBits-1:0] coord_t;

  // Input request: two segments, A to B and C to D.
  typedef struct packed {
    coord_t seg1_start_x;
    coord_t seg1_start_y;
    coord_t seg1_end_x;
    coord_t seg1_end_y;
    coord_t seg2_start_x;
    coord_t seg2_start_y;
    coord_t seg2_end_x;
    coord_t seg2_end_y;
  } lsi_in_t;

  // Result request.
  typedef struct packed {
    logic   hit;
    coord_t point_x;
    coord_t point_y;
  } lsi_out_t;

  // Crossing test results handed from the front end to the scaling stages.
  typedef struct packed {
    logic                 hit;
    logic [MagBits-1:0]   tnum_mag;
    logic [MagBits-1:0]   den_mag;
    logic [CoordBits-1:0] rx_mag;
    logic [CoordBits-1:0] ry_mag;
    logic                 rx_neg;
    logic                 ry_neg;
    coord_t               ax;
    coord_t               ay;
  } lsi_geo_t;

  // Values that ride alongside the dividers to the output stage.
  typedef struct packed {
    logic   hit;
    logic   rx_neg;
    logic   ry_neg;
    coord_t ax;
    coord_t ay;
  } lsi_side_t;

  // Sign-extend a coordinate by one bit.
  function automatic logic signed [DiffBits-1:0] ext_coord(coord_t c);
    return {c[CoordBits-1], c};
  endfunction

  // Sign-extend a product by one bit.
  function automatic logic signed [CrossBits-1:0] ext_prod(logic signed [ProdBits-1:0] p);
    return {p[ProdBits-1], p};
  endfunction

  // Magnitude of a cross product.
  function automatic logic [MagBits-1:0] cross_mag(logic signed [CrossBits-1:0] v);
    logic [CrossBits-1:0] n;
    n = v[CrossBits-1] ? (~v + CrossBits'(1)) : v;
    return n[MagBits-1:0];
  endfunction

  // Magnitude of a coordinate difference; it always fits the coordinate width.
  function automatic logic [CoordBits-1:0] diff_mag(logic signed [DiffBits-1:0] v);
    logic [DiffBits-1:0] n;
    n = v[DiffBits-1] ? (~v + DiffBits'(1)) : v;
    return n[CoordBits-1:0];
  endfunction

endpackage

### hw/rtl/line_segment_intersect.sv
// Top level of the two-segment crossing pipeline; output register and flow control.
// Instantiates lsi_front, lsi_scale and two lsi_div; depends on lsi_pkg.
//
// Usage:
//   A request on the input channel carries segment A-B and segment C-D in signed
//   Q7.8. It is taken at a clock edge where in_valid_i is high and in_stall_o is
//   low. Each request yields exactly one result on the output channel: hit, and
//   the crossing point, which reads zero when there is no hit.
//   A request passes four front stages, two scaling stages, one divider stage per
//   quotient bit and the output register. Throughput is one request per cycle while
//   the receiver does not stall; every stage is registered and the divider issues a
//   quotient bit per stage, so a new request enters each cycle the pipeline moves.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall_o rises in the same cycle; nothing is lost or repeated. While the
//   output register is empty or being taken, requests keep flowing.
//   Reset clears all valid bits; no result appears until a request has passed.
module line_segment_intersect import lsi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lsi_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lsi_out_t out_data_o
);

  logic                 pipe_en;
  logic                 front_valid, scale_valid;
  lsi_geo_t             geo;
  logic [DivBits-1:0]   dvd_x, dvd_y;
  logic [MagBits-1:0]   divisor;
  lsi_side_t            side_s;
  logic [CoordBits-1:0] quot_x, quot_y;

  lsi_side_t            side_q [CoordBits];
  logic [CoordBits-1:0] dvalid_q;
  logic                 out_valid_q;
  lsi_out_t             out_q;
  lsi_out_t             out_d;
  lsi_side_t            side_end;
  logic signed [CoordBits:0] off_x, off_y, sum_x, sum_y;

  // The pipeline moves unless a held result is stalled at the output.
  assign pipe_en    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !pipe_en;

  lsi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .valid_i(in_valid_i),
    .data_i (in_data_i),
    .valid_o(front_valid),
    .geo_o  (geo)
  );

  lsi_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .valid_i     (front_valid),
    .geo_i       (geo),
    .valid_o     (scale_valid),
    .dividend_x_o(dvd_x),
    .dividend_y_o(dvd_y),
    .divisor_o   (divisor),
    .side_o      (side_s)
  );

  lsi_div u_div_x (
    .clk_i     (clk_i),
    .en_i      (pipe_en),
    .dividend_i(dvd_x),
    .divisor_i (divisor),
    .quot_o    (quot_x)
  );

  lsi_div u_div_y (
    .clk_i     (clk_i),
    .en_i      (pipe_en),
    .dividend_i(dvd_y),
    .divisor_i (divisor),
    .quot_o    (quot_y)
  );

  // Valid bits alongside the divider stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvalid_q <= '0;
    end else if (pipe_en) begin
      dvalid_q <= {dvalid_q[CoordBits-2:0], scale_valid};
    end
  end

  // Side values delayed to match the divider.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      side_q[0] <= side_s;
      for (int k = 1; k < CoordBits; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign side_end = side_q[CoordBits-1];

  // Crossing point: start point plus the signed offset; zero when there is no hit.
  always_comb begin
    off_x = side_end.rx_neg ? -$signed({1'b0, quot_x}) : $signed({1'b0, quot_x});
    off_y = side_end.ry_neg ? -$signed({1'b0, quot_y}) : $signed({1'b0, quot_y});
    sum_x = ext_coord(side_end.ax) + off_x;
    sum_y = ext_coord(side_end.ay) + off_y;
    out_d.hit     = side_end.hit;
    out_d.point_x = side_end.hit ? sum_x[CoordBits-1:0] : '0;
    out_d.point_y = side_end.hit ? sum_y[CoordBits-1:0] : '0;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= dvalid_q[CoordBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The input side only stalls behind a held, stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output");

  // A result without a hit carries a zero point.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |-> (out_data_o.point_x == 0 && out_data_o.point_y == 0))
    else $error("miss with nonzero point");

  // A valid item leaving the dividers reaches the output register.
  a_div_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && dvalid_q[CoordBits-1]) |=> out_valid_o)
    else $error("result dropped at output register");

endmodule

### hw/rtl/lsi_front.sv
// Front end of the crossing pipeline: differences, products, cross products, range test.
// Four register stages; depends on lsi_pkg.
module lsi_front import lsi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  lsi_in_t  data_i,
  output logic     valid_o,
  output lsi_geo_t geo_o
);

  logic [3:0] valid_q;

  // Stage 1: direction and offset vectors.
  logic signed [DiffBits-1:0] rx1_q, ry1_q, sx1_q, sy1_q, wx1_q, wy1_q;
  coord_t                     ax1_q, ay1_q;

  // Stage 2: the six products.
  logic signed [ProdBits-1:0] p_rs_q, p_rsx_q, p_ws_q, p_wsx_q, p_rw_q, p_rwx_q;
  logic signed [DiffBits-1:0] rx2_q, ry2_q;
  coord_t                     ax2_q, ay2_q;

  // Stage 3: denominator and the two numerators.
  logic signed [CrossBits-1:0] den_q, tnum_q, unum_q;
  logic signed [DiffBits-1:0]  rx3_q, ry3_q;
  coord_t                      ax3_q, ay3_q;

  // Stage 4: result of the range test.
  lsi_geo_t geo_q;
  lsi_geo_t geo_d;
  logic     den_pos, t_ok, u_ok;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx1_q <= ext_coord(data_i.seg1_end_x) - ext_coord(data_i.seg1_start_x);
      ry1_q <= ext_coord(data_i.seg1_end_y) - ext_coord(data_i.seg1_start_y);
      sx1_q <= ext_coord(data_i.seg2_start_x) - ext_coord(data_i.seg2_end_x);
      sy1_q <= ext_coord(data_i.seg2_start_y) - ext_coord(data_i.seg2_end_y);
      wx1_q <= ext_coord(data_i.seg2_start_x) - ext_coord(data_i.seg1_start_x);
      wy1_q <= ext_coord(data_i.seg2_start_y) - ext_coord(data_i.seg1_start_y);
      ax1_q <= data_i.seg1_start_x;
      ay1_q <= data_i.seg1_start_y;

      p_rs_q  <= rx1_q * sy1_q;
      p_rsx_q <= ry1_q * sx1_q;
      p_ws_q  <= wx1_q * sy1_q;
      p_wsx_q <= wy1_q * sx1_q;
      p_rw_q  <= rx1_q * wy1_q;
      p_rwx_q <= ry1_q * wx1_q;
      rx2_q   <= rx1_q;
      ry2_q   <= ry1_q;
      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;

      den_q  <= ext_prod(p_rs_q) - ext_prod(p_rsx_q);
      tnum_q <= ext_prod(p_ws_q) - ext_prod(p_wsx_q);
      unum_q <= ext_prod(p_rw_q) - ext_prod(p_rwx_q);
      rx3_q  <= rx2_q;
      ry3_q  <= ry2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;

      geo_q <= geo_d;
    end
  end

  // Both parameters must lie in [0, 1]; checked by signs and compares, no division.
  always_comb begin
    den_pos = !den_q[CrossBits-1];
    if (den_pos) begin
      t_ok = !tnum_q[CrossBits-1] && (tnum_q <= den_q);
      u_ok = !unum_q[CrossBits-1] && (unum_q <= den_q);
    end else begin
      t_ok = (tnum_q <= 0) && (tnum_q >= den_q);
      u_ok = (unum_q <= 0) && (unum_q >= den_q);
    end
    geo_d.hit      = (den_q != 0) && t_ok && u_ok;
    geo_d.tnum_mag = cross_mag(tnum_q);
    geo_d.den_mag  = cross_mag(den_q);
    geo_d.rx_mag   = diff_mag(rx3_q);
    geo_d.ry_mag   = diff_mag(ry3_q);
    geo_d.rx_neg   = rx3_q[DiffBits-1];
    geo_d.ry_neg   = ry3_q[DiffBits-1];
    geo_d.ax       = ax3_q;
    geo_d.ay       = ay3_q;
  end

  assign valid_o = valid_q[3];
  assign geo_o   = geo_q;

endmodule

### hw/rtl/lsi_scale.sv
// Scaling stages: forms numerator times direction for x and y as two partial products.
// Two register stages; depends on lsi_pkg.
module lsi_scale import lsi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  lsi_geo_t           geo_i,
  output logic               valid_o,
  output logic [DivBits-1:0] dividend_x_o,
  output logic [DivBits-1:0] dividend_y_o,
  output logic [MagBits-1:0] divisor_o,
  output lsi_side_t          side_o
);

  logic [1:0]          valid_q;
  logic [PartBits-1:0] pp_xl_q, pp_xh_q, pp_yl_q, pp_yh_q;
  logic [MagBits-1:0]  den1_q, den2_q;
  lsi_side_t           side1_q, side2_q;
  lsi_side_t           side_d;
  logic [DivBits-1:0]  dvd_x_q, dvd_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_comb begin
    side_d.hit    = geo_i.hit;
    side_d.rx_neg = geo_i.rx_neg;
    side_d.ry_neg = geo_i.ry_neg;
    side_d.ax     = geo_i.ax;
    side_d.ay     = geo_i.ay;
  end

  // Partial products in the first stage, shifted sum in the second.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_xl_q <= geo_i.tnum_mag[HalfBits-1:0] * geo_i.rx_mag;
      pp_xh_q <= geo_i.tnum_mag[MagBits-1:HalfBits] * geo_i.rx_mag;
      pp_yl_q <= geo_i.tnum_mag[HalfBits-1:0] * geo_i.ry_mag;
      pp_yh_q <= geo_i.tnum_mag[MagBits-1:HalfBits] * geo_i.ry_mag;
      den1_q  <= geo_i.den_mag;
      side1_q <= side_d;

      dvd_x_q <= DivBits'(pp_xl_q) + (DivBits'(pp_xh_q) << HalfBits);
      dvd_y_q <= DivBits'(pp_yl_q) + (DivBits'(pp_yh_q) << HalfBits);
      den2_q  <= den1_q;
      side2_q <= side1_q;
    end
  end

  assign valid_o      = valid_q[1];
  assign dividend_x_o = dvd_x_q;
  assign dividend_y_o = dvd_y_q;
  assign divisor_o    = den2_q;
  assign side_o       = side2_q;

endmodule

### hw/rtl/lsi_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// The dividend's quotient must fit CoordBits bits; depends on lsi_pkg.
module lsi_div import lsi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DivBits-1:0]   dividend_i,
  input  logic [MagBits-1:0]   divisor_i,
  output logic [CoordBits-1:0] quot_o
);

  localparam int Steps = CoordBits;

  logic [MagBits-1:0]   rem_q [Steps];
  logic [CoordBits-1:0] low_q [Steps];
  logic [CoordBits-1:0] quo_q [Steps];
  logic [MagBits-1:0]   dsr_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [MagBits-1:0]   rem_in, dsr_in, rem_d;
    logic [CoordBits-1:0] low_in, quo_in;
    logic [MagBits:0]     trial, diff;
    logic                 ge;

    // The first stage starts from the upper dividend bits, which lie below the divisor.
    if (k == 0) begin : g_first
      assign rem_in = dividend_i[DivBits-1:CoordBits];
      assign low_in = dividend_i[CoordBits-1:0];
      assign quo_in = '0;
      assign dsr_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign dsr_in = dsr_q[k-1];
    end

    // Shift in the next dividend bit and subtract where it fits.
    always_comb begin
      trial = {rem_in, low_in[CoordBits-1]};
      diff  = trial - {1'b0, dsr_in};
      ge    = (trial >= {1'b0, dsr_in});
      rem_d = ge ? diff[MagBits-1:0] : trial[MagBits-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        low_q[k] <= {low_in[CoordBits-2:0], 1'b0};
        quo_q[k] <= {quo_in[CoordBits-2:0], ge};
        dsr_q[k] <= dsr_in;
      end
    end
  end

  assign quot_o = quo_q[Steps-1];

endmodule
